@@ design/ssqwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-server queue wait monitor package
// Shared constants, register indexes and field widths of the queue monitor.
// ----------------------------------------------------------------------------
package ssqwm_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    localparam int DRAW_WIDTH    = 11;
    localparam int FREQ_WIDTH    = 11;
    localparam int SERVICE_WIDTH = 16;
    localparam int TICK_WIDTH    = 32;
    localparam int CFG_WIDTH     = 16;
    localparam int PRODUCT_WIDTH = DRAW_WIDTH + FREQ_WIDTH;

    // An arrival occurs when draw times frequency is at most one, in 1/1024 units.
    localparam logic [PRODUCT_WIDTH-1:0] ARRIVAL_LIMIT = PRODUCT_WIDTH'(1024);

    localparam logic [SERVICE_WIDTH-1:0] SERVICE_TIME_RESET = SERVICE_WIDTH'(1);
    localparam logic [FREQ_WIDTH-1:0]    ARRIVAL_FREQ_RESET = FREQ_WIDTH'(1);

    typedef enum logic [0:0] {
        REG_SERVICE_TIME      = 1'b0,
        REG_ARRIVAL_FREQUENCY = 1'b1
    } cfg_index_t;

endpackage

@@ design/single_server_queue_wait_monitor.sv @@
// ----------------------------------------------------------------------------
// Single-server queue wait monitor
// Simulates one tick of a single-server queue per input transaction, keeping
// arrival stamps in a circular memory and tracking the longest wait seen.
// ----------------------------------------------------------------------------
// Results are registered in the output buffer before they appear on the m_ side.
// Throughput: one transaction per cycle while the output buffer has room; a two-entry
// output buffer lets one more input be taken while a result waits to be taken.
// Reset: aresetn clears tick count, queue pointers, busy counter, longest wait
// and the output buffer; service_time and arrival_frequency return to 1.
// The stamp memory is not cleared; only written entries are ever read.
module single_server_queue_wait_monitor #(
    parameter int QUEUE_DEPTH = ssqwm_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [ssqwm_pkg::CFG_WIDTH-1:0]      cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ssqwm_pkg::DRAW_WIDTH-1:0]     s_draw,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_arrived,
    output logic                                 m_dropped,
    output logic                                 m_served,
    output logic [ssqwm_pkg::TICK_WIDTH-1:0]     m_wait_time,
    output logic [ssqwm_pkg::TICK_WIDTH-1:0]     m_max_wait,
    output logic [CountWidth-1:0]                m_queue_level,
    output logic [ssqwm_pkg::SERVICE_WIDTH-1:0]  m_busy_left
);

    localparam int IdxWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        logic                                arrived;
        logic                                dropped;
        logic                                served;
        logic [ssqwm_pkg::TICK_WIDTH-1:0]    wait_time;
        logic [ssqwm_pkg::TICK_WIDTH-1:0]    max_wait;
        logic [CountWidth-1:0]               queue_level;
        logic [ssqwm_pkg::SERVICE_WIDTH-1:0] busy_left;
    } result_t;

    function automatic logic [IdxWidth-1:0] next_slot(input logic [IdxWidth-1:0] idx);
        next_slot = (idx == IdxWidth'(QUEUE_DEPTH - 1)) ? '0 : idx + IdxWidth'(1);
    endfunction

    logic [ssqwm_pkg::SERVICE_WIDTH-1:0] service_time_reg;
    logic [ssqwm_pkg::FREQ_WIDTH-1:0]    arrival_freq_reg;

    logic [ssqwm_pkg::TICK_WIDTH-1:0]    tick_reg, tick_next;
    logic [IdxWidth-1:0]                 head_reg, head_next;
    logic [IdxWidth-1:0]                 tail_reg, tail_next;
    logic [CountWidth-1:0]               count_reg, count_next;
    logic [ssqwm_pkg::SERVICE_WIDTH-1:0] busy_reg, busy_next;
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    longest_reg, longest_next;
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    head_stamp_reg, head_stamp_next;

    logic [ssqwm_pkg::TICK_WIDTH-1:0]    stamp_mem [QUEUE_DEPTH];
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    ahead_data_reg;
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    ahead_bypass_data_reg;
    logic                                ahead_bypass_reg;
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    ahead_stamp;
    logic [IdxWidth-1:0]                 rd_addr;

    result_t                             out_reg, skid_reg, result;
    logic                                out_valid_reg, skid_valid_reg;

    logic                                accept;
    logic [ssqwm_pkg::PRODUCT_WIDTH-1:0] product;
    logic                                arrival, push, pop;
    logic [ssqwm_pkg::TICK_WIDTH-1:0]    wait_value;
    logic [ssqwm_pkg::SERVICE_WIDTH-1:0] busy_loaded;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            service_time_reg <= ssqwm_pkg::SERVICE_TIME_RESET;
            arrival_freq_reg <= ssqwm_pkg::ARRIVAL_FREQ_RESET;
        end else if (cfg_we) begin
            unique case (ssqwm_pkg::cfg_index_t'(cfg_index))
                ssqwm_pkg::REG_SERVICE_TIME: begin
                    service_time_reg <= cfg_wdata;
                end
                ssqwm_pkg::REG_ARRIVAL_FREQUENCY: begin
                    arrival_freq_reg <= cfg_wdata[ssqwm_pkg::FREQ_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The entry behind the head comes from memory, or from a write in the same cycle.
    assign ahead_stamp = ahead_bypass_reg ? ahead_bypass_data_reg : ahead_data_reg;

    always_comb begin
        product    = ssqwm_pkg::PRODUCT_WIDTH'(s_draw)
                     * ssqwm_pkg::PRODUCT_WIDTH'(arrival_freq_reg);
        arrival    = (product <= ssqwm_pkg::ARRIVAL_LIMIT);
        push       = arrival && (count_reg != CountWidth'(QUEUE_DEPTH));
        pop        = (busy_reg == '0) && ((count_reg != '0) || push);
        wait_value = '0;
        if (pop && (count_reg != '0)) begin
            wait_value = tick_reg - head_stamp_reg;
        end

        tail_next  = push ? next_slot(tail_reg) : tail_reg;
        head_next  = pop ? next_slot(head_reg) : head_reg;
        count_next = count_reg + CountWidth'(push) - CountWidth'(pop);

        if (pop) begin
            head_stamp_next = (count_reg == CountWidth'(1)) ? tick_reg : ahead_stamp;
        end else begin
            head_stamp_next = (count_reg == '0) ? tick_reg : head_stamp_reg;
        end

        busy_loaded  = pop ? service_time_reg : busy_reg;
        busy_next    = (busy_loaded != '0) ? busy_loaded - ssqwm_pkg::SERVICE_WIDTH'(1)
                                           : busy_loaded;
        longest_next = (pop && (wait_value > longest_reg)) ? wait_value : longest_reg;
        tick_next    = tick_reg + ssqwm_pkg::TICK_WIDTH'(1);

        result.arrived     = push;
        result.dropped     = arrival && !push;
        result.served      = pop;
        result.wait_time   = wait_value;
        result.max_wait    = longest_next;
        result.queue_level = count_next;
        result.busy_left   = busy_next;

        rd_addr = next_slot(accept ? head_next : head_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            busy_reg    <= '0;
            longest_reg <= '0;
        end else if (accept) begin
            tick_reg    <= tick_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            longest_reg <= longest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            head_stamp_reg <= head_stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && push) begin
            stamp_mem[tail_reg] <= tick_reg;
        end
        ahead_data_reg        <= stamp_mem[rd_addr];
        ahead_bypass_reg      <= accept && push && (tail_reg == rd_addr);
        ahead_bypass_data_reg <= tick_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_arrived     = out_reg.arrived;
    assign m_dropped     = out_reg.dropped;
    assign m_served      = out_reg.served;
    assign m_wait_time   = out_reg.wait_time;
    assign m_max_wait    = out_reg.max_wait;
    assign m_queue_level = out_reg.queue_level;
    assign m_busy_left   = out_reg.busy_left;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountWidth'(QUEUE_DEPTH))
        else $error("Queue count exceeds the queue depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("Empty queue with head and tail apart.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (busy_reg != '0))
            |=> (busy_reg == $past(busy_reg) - ssqwm_pkg::SERVICE_WIDTH'(1)))
        else $error("Busy counter did not count down on a busy tick.");

endmodule

@@ sim/tb_single_server_queue_wait_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the single-server queue wait monitor
// Each draw transaction is one simulated tick. The bench predicts the
// arrival, drop and service outcome of every tick and checks each result
// transaction field by field. It runs a short directed sequence and then
// random phases under several register settings. The sender and the receiver
// idle and stall at random, and there are long receiver hold-offs that fill
// the block's buffering.
// ----------------------------------------------------------------------------
module tb_single_server_queue_wait_monitor;
    import ssqwm_pkg::*;

    localparam int QDEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int LEVEL_W = $clog2(QDEPTH + 1);
    localparam int SWAP_AT = 580;
    localparam int CALM_AT = 1160;
    localparam int HOLD_LEN = 200;
    localparam int HOLD_EVERY = 800;
    localparam int MAX_PRINTS = 50;

    localparam int NUM_SEGS = 5;
    localparam int SEG_SVC[NUM_SEGS] = '{1, 1, 0, 3, 2};
    localparam int SEG_FREQ[NUM_SEGS] = '{1, 0, 2, 1024, 2047};
    localparam int SEG_LEN[NUM_SEGS] = '{7, 4, 4, 5, 3};
    localparam int DIRECTED_DRAWS[23] = '{
        0, 1024, 1025, 2047, 1, 512, 0,
        2047, 1025, 1024, 0,
        512, 513, 0, 512,
        1, 2, 0, 1, 1,
        0, 1, 0
    };

    localparam int NUM_PHASES = 9;
    localparam int PHASE_SVC[NUM_PHASES] = '{2, 0, 5, 1, 4, 0, 300, 0, 65535};
    localparam int PHASE_FREQ[NUM_PHASES] = '{2, 1, 0, 1024, 3, 0, 0, 2047, 0};
    localparam int PHASE_LEN[NUM_PHASES] = '{200, 200, 200, 200, 250, 150, 100, 200, 150};

    typedef struct packed {
        logic                     arrived;
        logic                     dropped;
        logic                     served;
        logic [TICK_WIDTH-1:0]    wait_time;
        logic [TICK_WIDTH-1:0]    max_wait;
        logic [LEVEL_W-1:0]       queue_level;
        logic [SERVICE_WIDTH-1:0] busy_left;
    } tick_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    cfg_index_t               cfg_index = REG_SERVICE_TIME;
    logic [CFG_WIDTH-1:0]     cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [DRAW_WIDTH-1:0]    s_draw = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_arrived;
    logic                     m_dropped;
    logic                     m_served;
    logic [TICK_WIDTH-1:0]    m_wait_time;
    logic [TICK_WIDTH-1:0]    m_max_wait;
    logic [LEVEL_W-1:0]       m_queue_level;
    logic [SERVICE_WIDTH-1:0] m_busy_left;

    // Own copy of the queue simulation.
    logic [SERVICE_WIDTH-1:0] service_ticks = SERVICE_TIME_RESET;
    logic [FREQ_WIDTH-1:0]    arrival_freq = ARRIVAL_FREQ_RESET;
    logic [TICK_WIDTH-1:0]    now_tick = '0;
    logic [TICK_WIDTH-1:0]    stamp_mem [QDEPTH];
    int                       head_slot = 0;
    int                       tail_slot = 0;
    int                       waiting = 0;
    logic [SERVICE_WIDTH-1:0] busy_ticks = '0;
    logic [TICK_WIDTH-1:0]    longest_wait = '0;

    logic [DRAW_WIDTH-1:0]    draw_queue [$];
    tick_result_t             expected_ticks [$];
    int                       items_queued = 0;
    int                       items_sent = 0;
    int                       results_seen = 0;
    int                       error_count = 0;
    int                       hold_left = 0;
    int                       next_hold = 400;

    single_server_queue_wait_monitor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_draw        (s_draw),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_arrived     (m_arrived),
        .m_dropped     (m_dropped),
        .m_served      (m_served),
        .m_wait_time   (m_wait_time),
        .m_max_wait    (m_max_wait),
        .m_queue_level (m_queue_level),
        .m_busy_left   (m_busy_left)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_single_server_queue_wait_monitor: done, errors");
        $finish;
    end

    function automatic tick_result_t simulate_tick(input logic [DRAW_WIDTH-1:0] draw);
        tick_result_t r;
        int unsigned  product;
        r = '0;
        product = 32'(draw) * 32'(arrival_freq);
        if (product <= 1024) begin
            if (waiting < QDEPTH) begin
                stamp_mem[tail_slot] = now_tick;
                tail_slot = (tail_slot + 1) % QDEPTH;
                waiting++;
                r.arrived = 1'b1;
            end else begin
                r.dropped = 1'b1;
            end
        end
        if (busy_ticks == 0 && waiting != 0) begin
            r.wait_time = now_tick - stamp_mem[head_slot];
            head_slot = (head_slot + 1) % QDEPTH;
            waiting--;
            busy_ticks = service_ticks;
            r.served = 1'b1;
            if (r.wait_time > longest_wait) begin
                longest_wait = r.wait_time;
            end
        end
        now_tick++;
        if (busy_ticks != 0) begin
            busy_ticks--;
        end
        r.max_wait = longest_wait;
        r.queue_level = LEVEL_W'(waiting);
        r.busy_left = busy_ticks;
        return r;
    endfunction

    function automatic logic [DRAW_WIDTH-1:0] pick_draw(input int freq);
        int sel;
        int limit_pt;
        int v;
        sel = $urandom_range(0, 99);
        limit_pt = (freq != 0) ? 1024 / freq : 1024;
        if (sel < 35) begin
            v = $urandom_range(0, 2047);
        end else if (sel < 65) begin
            v = limit_pt + int'($urandom_range(0, 4)) - 2;
        end else if (sel < 85) begin
            v = $urandom_range(0, limit_pt);
        end else begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = 1024;
                2: v = 1025;
                default: v = 2047;
            endcase
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 2047) begin
            v = 2047;
        end
        return DRAW_WIDTH'(v);
    endfunction

    function automatic int sender_idle_pct();
        if (items_sent < SWAP_AT) begin
            return 21;
        end else if (items_sent < CALM_AT) begin
            return 88;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_sent < SWAP_AT) begin
            return 88;
        end else if (items_sent < CALM_AT) begin
            return 21;
        end
        return 0;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("ERROR result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
        end
    endtask

    task automatic add_draw(input int value);
        draw_queue.push_back(DRAW_WIDTH'(value));
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic reconfigure(input int svc, input int freq);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SERVICE_TIME;
        cfg_wdata <= CFG_WIDTH'(svc);
        @(posedge aclk);
        cfg_index <= REG_ARRIVAL_FREQUENCY;
        cfg_wdata <= CFG_WIDTH'(freq);
        @(posedge aclk);
        cfg_we <= 1'b0;
        service_ticks = SERVICE_WIDTH'(svc);
        arrival_freq = FREQ_WIDTH'(freq);
    endtask

    always @(posedge aclk) begin : draw_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_ticks.push_back(simulate_tick(s_draw));
                items_sent <= items_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (draw_queue.size() != 0 &&
                    (hold_left != 0 || $urandom_range(0, 99) >= sender_idle_pct())) begin
                    s_valid <= 1'b1;
                    s_draw <= draw_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : stall_timer
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (items_sent >= next_hold) begin
            hold_left <= HOLD_LEN;
            next_hold <= next_hold + HOLD_EVERY;
        end
    end

    always @(posedge aclk) begin : result_monitor
        tick_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_ticks.size() == 0) begin
                    flag_error("unexpected transaction", 32'd1, 32'd0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (m_arrived !== want.arrived) begin
                        flag_error("arrived", 32'(m_arrived), 32'(want.arrived));
                    end
                    if (m_dropped !== want.dropped) begin
                        flag_error("dropped", 32'(m_dropped), 32'(want.dropped));
                    end
                    if (m_served !== want.served) begin
                        flag_error("served", 32'(m_served), 32'(want.served));
                    end
                    if (m_wait_time !== want.wait_time) begin
                        flag_error("wait_time", m_wait_time, want.wait_time);
                    end
                    if (m_max_wait !== want.max_wait) begin
                        flag_error("max_wait", m_max_wait, want.max_wait);
                    end
                    if (m_queue_level !== want.queue_level) begin
                        flag_error("queue_level", 32'(m_queue_level), 32'(want.queue_level));
                    end
                    if (m_busy_left !== want.busy_left) begin
                        flag_error("busy_left", 32'(m_busy_left), 32'(want.busy_left));
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    initial begin : stimulus
        int pos;
        pos = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // The first segment runs with the register values left by reset.
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            if (seg != 0) begin
                reconfigure(SEG_SVC[seg], SEG_FREQ[seg]);
            end
            for (int i = 0; i < SEG_LEN[seg]; i++) begin
                add_draw(DIRECTED_DRAWS[pos]);
                pos++;
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            reconfigure(PHASE_SVC[ph], PHASE_FREQ[ph]);
            for (int i = 0; i < PHASE_LEN[ph]; i++) begin
                add_draw(pick_draw(PHASE_FREQ[ph]));
            end
        end

        wait_drained();
        repeat (5) @(posedge aclk);
        if (expected_ticks.size() != 0) begin
            flag_error("transactions missing", 32'd0, 32'(expected_ticks.size()));
        end
        if (error_count == 0) begin
            $display("tb_single_server_queue_wait_monitor: done, clean");
        end else begin
            $display("tb_single_server_queue_wait_monitor: done, errors");
        end
        $finish;
    end

endmodule
